// ----- design/dcta_pkg.sv -----
// ----------------------------------------------------------------------------
// dcta_pkg
// Shared types and codes for the debounced contact timeout alarm.
// ----------------------------------------------------------------------------
package dcta_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_ACTIVE_HIGH = 2'd2;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [31:0] TIMEOUT_RESET  = 32'd30000;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_TIMING = 2'd1,
		PH_ALARM  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_RISE = 2'd1,
		EV_FALL = 2'd2
	} contact_event_t;

	typedef struct packed {
		logic [15:0] debounce_ticks;
		logic [31:0] timeout_ticks;
		logic        light_active_high;
	} cfg_t;

	typedef struct packed {
		phase_t         mode;
		logic           light_drive;
		contact_event_t contact_event;
		logic [31:0]    elapsed_ticks;
		logic           stable_level;
	} result_t;

endpackage

// ----- design/dcta_cfg.sv -----
// ----------------------------------------------------------------------------
// dcta_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dcta_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dcta_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dcta_pkg::CFG_DATA_W-1:0]   cfg_data,
	output dcta_pkg::cfg_t                    cfg
);
	import dcta_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks    <= DEBOUNCE_RESET;
			cfg_q.timeout_ticks     <= TIMEOUT_RESET;
			cfg_q.light_active_high <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE_TICKS:    cfg_q.debounce_ticks    <= cfg_data[15:0];
				CFG_TIMEOUT_TICKS:     cfg_q.timeout_ticks     <= cfg_data[31:0];
				CFG_LIGHT_ACTIVE_HIGH: cfg_q.light_active_high <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/dcta_core.sv -----
// ----------------------------------------------------------------------------
// dcta_core
// Debounce window, hold timer and phase machine; one tick per step.
// ----------------------------------------------------------------------------
module dcta_core #(
	parameter int WINDOW_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              level,
	input  dcta_pkg::cfg_t    cfg,
	output dcta_pkg::result_t res
);
	import dcta_pkg::*;

	localparam int CMP_W = (WINDOW_WIDTH > 16) ? WINDOW_WIDTH : 16;
	localparam logic [WINDOW_WIDTH-1:0] AGE_MAX = {WINDOW_WIDTH{1'b1}};

	logic                    last_sample_q;
	logic                    window_open_q;
	logic                    pending_level_q;
	logic                    accepted_level_q;
	logic [WINDOW_WIDTH-1:0] window_age_q;
	phase_t                  phase_q;
	logic [31:0]             hold_age_q;

	logic                    window_open_a;
	logic                    pending_level_a;
	logic [WINDOW_WIDTH-1:0] window_age_a;
	logic                    window_close;
	logic                    accept;
	logic [31:0]             hold_inc;
	logic [31:0]             hold_age_d;
	logic                    window_open_d;
	logic                    accepted_level_d;
	contact_event_t          event_d;
	phase_t                  phase_d;

	// advance debounce window and hold timer
	always_comb begin
		hold_inc = hold_age_q;
		if (phase_q != PH_IDLE && hold_age_q != 32'hFFFF_FFFF) begin
			hold_inc = hold_age_q + 32'd1;
		end
		window_open_a   = window_open_q;
		pending_level_a = pending_level_q;
		window_age_a    = window_age_q;
		if (level != last_sample_q) begin
			window_open_a   = 1'b1;
			pending_level_a = level;
			window_age_a    = '0;
		end else if (window_open_q && window_age_q != AGE_MAX) begin
			window_age_a = window_age_q + WINDOW_WIDTH'(1);
		end
		window_close = window_open_a &&
			(CMP_W'(window_age_a) >= CMP_W'(cfg.debounce_ticks));
		accept        = window_close && (pending_level_a != accepted_level_q);
		window_open_d = window_open_a && !window_close;
		accepted_level_d = accept ? pending_level_a : accepted_level_q;
		hold_age_d       = accept ? 32'd0 : hold_inc;
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			phase_d = pending_level_a ? PH_TIMING : PH_IDLE;
		end
		if (phase_d == PH_TIMING && hold_age_d >= cfg.timeout_ticks) begin
			phase_d = PH_ALARM;
		end
	end

	// result of this tick
	always_comb begin
		event_d = EV_NONE;
		if (accept) begin
			event_d = pending_level_a ? EV_RISE : EV_FALL;
		end
		res.mode          = phase_d;
		res.light_drive   = (phase_d == PH_ALARM) ~^ cfg.light_active_high;
		res.contact_event = event_d;
		res.elapsed_ticks = (phase_d == PH_IDLE) ? 32'd0 : hold_age_d;
		res.stable_level  = accepted_level_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q    <= 1'b0;
			window_open_q    <= 1'b0;
			pending_level_q  <= 1'b0;
			accepted_level_q <= 1'b0;
			window_age_q     <= '0;
			phase_q          <= PH_IDLE;
			hold_age_q       <= '0;
		end else if (step) begin
			last_sample_q    <= level;
			window_open_q    <= window_open_d;
			pending_level_q  <= pending_level_a;
			accepted_level_q <= accepted_level_d;
			window_age_q     <= window_age_a;
			phase_q          <= phase_d;
			hold_age_q       <= hold_age_d;
		end
	end

endmodule

// ----- design/debounced_contact_timeout_alarm_top.sv -----
// ----------------------------------------------------------------------------
// debounced_contact_timeout_alarm_top
// Debounced contact monitor with hold-timeout alarm and polarity-set light.
// ----------------------------------------------------------------------------
// Takes one tick transaction per clock cycle while the output is not stalled
// and returns one result transaction per tick: the tick is held in an
// input register, the debounce and timer update runs in one pass, and the
// result lands in an output register. The output register lets a new tick
// enter while a result still waits; a stall on the output side holds both
// registers. Write configuration only while no tick is in flight.
module debounced_contact_timeout_alarm_top #(
	parameter int WINDOW_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              raw_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        mode,
	output logic                              light_drive,
	output logic [1:0]                        contact_event,
	output logic [31:0]                       elapsed_ticks,
	output logic                              stable_level,
	input  logic                              cfg_we,
	input  logic [dcta_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dcta_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dcta_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t result_s2;
	logic    valid_s1;
	logic    level_s1;
	logic    valid_s2;
	logic    advance;
	logic    step;

	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	dcta_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dcta_core #(
		.WINDOW_WIDTH (WINDOW_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= raw_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign mode          = result_s2.mode;
	assign light_drive   = result_s2.light_drive;
	assign contact_event = result_s2.contact_event;
	assign elapsed_ticks = result_s2.elapsed_ticks;
	assign stable_level  = result_s2.stable_level;

	a_idle_zero_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.mode == PH_IDLE |-> result_s2.elapsed_ticks == 32'd0)
		else $error("elapsed ticks nonzero while idle");

	a_rise_enters_timing: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.contact_event == EV_RISE
		|-> result_s2.mode != PH_IDLE && result_s2.stable_level)
		else $error("accepted rise without timing or high level");

	a_fall_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.contact_event == EV_FALL
		|-> result_s2.mode == PH_IDLE && !result_s2.stable_level)
		else $error("accepted fall without idle or low level");

	a_stall_holds_core: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> $stable(result_s2) && !$past(step))
		else $error("core stepped while result stalled");

endmodule

// ----- tb/debounced_contact_timeout_alarm_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// debounced_contact_timeout_alarm_top_test
// Self-checking bench for the debounced contact monitor with hold alarm.
// ----------------------------------------------------------------------------
// Drives millisecond tick transactions into the block and checks every status
// transaction against a cycle-free model of the debounce window, the hold
// timer, the alarm and the light polarity. A short table covers reset values,
// zero and full-scale settings and the glitch cases. A contact hold under the
// full-scale debounce setting stays unaccepted. Random phases follow with
// contact runs, glitches and noise under changing settings. Sender bursts and
// receiver stalls are random throughout.
// ----------------------------------------------------------------------------
module debounced_contact_timeout_alarm_top_test;
	import dcta_pkg::*;

	localparam int WIN_W = 16;
	localparam int CYCLE_LIMIT = 200_000;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		int      sel;
		logic    raw;
		bit      fixed;
		result_t want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   raw_level;
	logic                   out_valid;
	logic                   out_ready;
	logic [1:0]             mode;
	logic                   light_drive;
	logic [1:0]             contact_event;
	logic [31:0]            elapsed_ticks;
	logic                   stable_level;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	logic [15:0]      db_len;
	logic [31:0]      alarm_after;
	logic             light_pol;
	logic             prev_raw;
	logic             win_busy;
	logic             win_level;
	logic             deb_level;
	logic [WIN_W-1:0] win_count;
	phase_t           cur_phase;
	logic [31:0]      hold_count;

	result_t  pending_status[$];
	dir_row_t dir_rows[$];
	logic [31:0] set_db[4];
	logic [31:0] set_to[4];
	logic [31:0] set_pol[4];

	int errors;
	int cycles;
	int burst_left;
	int n_checked;
	int n_rise;
	int n_fall;
	int n_alarm;
	int n_settings;

	debounced_contact_timeout_alarm_top #(
		.WINDOW_WIDTH(WIN_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_level(raw_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mode(mode),
		.light_drive(light_drive),
		.contact_event(contact_event),
		.elapsed_ticks(elapsed_ticks),
		.stable_level(stable_level),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t advance_contact(input logic lvl);
		result_t r;
		contact_event_t ev;
		ev = EV_NONE;
		if (cur_phase != PH_IDLE && hold_count != '1)
			hold_count++;
		if (lvl != prev_raw) begin
			prev_raw = lvl;
			win_busy = 1'b1;
			win_level = lvl;
			win_count = '0;
		end else if (win_busy && win_count != '1) begin
			win_count++;
		end
		if (win_busy && win_count >= db_len) begin
			win_busy = 1'b0;
			if (win_level != deb_level) begin
				deb_level = win_level;
				hold_count = '0;
				if (deb_level) begin
					cur_phase = PH_TIMING;
					ev = EV_RISE;
					n_rise++;
				end else begin
					cur_phase = PH_IDLE;
					ev = EV_FALL;
					n_fall++;
				end
			end
		end
		if (cur_phase == PH_TIMING && hold_count >= alarm_after) begin
			cur_phase = PH_ALARM;
			n_alarm++;
		end
		r.mode = cur_phase;
		r.light_drive = (cur_phase == PH_ALARM) ~^ light_pol;
		r.contact_event = ev;
		r.elapsed_ticks = (cur_phase == PH_IDLE) ? 32'd0 : hold_count;
		r.stable_level = deb_level;
		return r;
	endfunction

	function automatic void add_row(input int sel, input logic raw, input bit fixed,
			input phase_t m, input logic d, input contact_event_t e,
			input logic [31:0] el, input logic st);
		dir_row_t row;
		row.sel = sel;
		row.raw = raw;
		row.fixed = fixed;
		row.want.mode = m;
		row.want.light_drive = d;
		row.want.contact_event = e;
		row.want.elapsed_ticks = el;
		row.want.stable_level = st;
		dir_rows.push_back(row);
	endfunction

	task automatic send_tick(input logic lvl, input bit fixed, input result_t want);
		result_t r;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
			repeat ($urandom_range(0, 5)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		raw_level <= lvl;
		do @(posedge clk); while (!in_ready);
		r = advance_contact(lvl);
		pending_status.push_back(fixed ? want : r);
	endtask

	task automatic settle;
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_DEBOUNCE_TICKS: db_len = data[15:0];
			CFG_TIMEOUT_TICKS: alarm_after = data;
			CFG_LIGHT_ACTIVE_HIGH: light_pol = data[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [31:0] db, input logic [31:0] to,
			input logic [31:0] pol);
		write_reg(CFG_LIGHT_ACTIVE_HIGH, pol);
		write_reg(CFG_UNUSED, $urandom);
		write_reg(CFG_DEBOUNCE_TICKS, db);
		write_reg(CFG_TIMEOUT_TICKS, to);
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic report_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles, %0d status transactions missing",
				cycles, pending_status.size());
			$display("debounced_contact_timeout_alarm_top_test NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				$display("%0t: status transaction with no tick outstanding, mode %0d",
					$time, mode);
				errors++;
			end else begin
				want = pending_status.pop_front();
				n_checked++;
				if (mode !== want.mode)
					report_field("mode", want.mode, mode);
				if (light_drive !== want.light_drive)
					report_field("light_drive", want.light_drive, light_drive);
				if (contact_event !== want.contact_event)
					report_field("contact_event", want.contact_event, contact_event);
				if (elapsed_ticks !== want.elapsed_ticks)
					report_field("elapsed_ticks", want.elapsed_ticks, elapsed_ticks);
				if (stable_level !== want.stable_level)
					report_field("stable_level", want.stable_level, stable_level);
			end
		end
	end

	initial begin
		int style;
		int span;
		int rx_count;
		int run_left;
		logic run_val;
		rx_count = 0;
		run_left = 0;
		run_val = 1'b0;
		out_ready = 1'b0;
		forever begin
			style = $urandom_range(0, 3);
			span = $urandom_range(40, 120);
			repeat (span) begin
				@(negedge clk);
				rx_count++;
				case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (rx_count % 4 == 0);
					default: begin
						if (run_left == 0) begin
							run_val = ~run_val;
							run_left = $urandom_range(1, 8);
						end
						run_left--;
						out_ready <= run_val;
					end
				endcase
			end
		end
	end

	initial begin
		int p;
		int sent;
		int run;
		int pick;
		logic [31:0] db;
		logic [31:0] to;
		logic [15:0] hi;
		logic lvl;
		result_t none;
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_level = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		none = '0;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		n_checked = 0;
		n_rise = 0;
		n_fall = 0;
		n_alarm = 0;
		n_settings = 0;
		db_len = DEBOUNCE_RESET;
		alarm_after = TIMEOUT_RESET;
		light_pol = 1'b1;
		prev_raw = 1'b0;
		win_busy = 1'b0;
		win_level = 1'b0;
		deb_level = 1'b0;
		win_count = '0;
		cur_phase = PH_IDLE;
		hold_count = '0;

		set_db[1] = 32'h0000_0000; set_to[1] = 32'h0000_0000; set_pol[1] = 32'h0000_0000;
		set_db[2] = 32'h0000_0002; set_to[2] = 32'h0000_0003; set_pol[2] = 32'h0000_0001;
		set_db[3] = 32'hABCD_FFFF; set_to[3] = 32'hFFFF_FFFF; set_pol[3] = 32'hFFFF_FFFE;

		add_row(0, 1'b0, 1, PH_IDLE, 1'b0, EV_NONE, 32'd0, 1'b0);
		add_row(0, 1'b1, 1, PH_IDLE, 1'b0, EV_NONE, 32'd0, 1'b0);
		add_row(0, 1'b0, 1, PH_IDLE, 1'b0, EV_NONE, 32'd0, 1'b0);
		add_row(0, 1'b0, 1, PH_IDLE, 1'b0, EV_NONE, 32'd0, 1'b0);
		add_row(1, 1'b1, 1, PH_ALARM, 1'b0, EV_RISE, 32'd0, 1'b1);
		add_row(0, 1'b1, 1, PH_ALARM, 1'b0, EV_NONE, 32'd1, 1'b1);
		add_row(0, 1'b0, 1, PH_IDLE, 1'b1, EV_FALL, 32'd0, 1'b0);
		add_row(0, 1'b0, 1, PH_IDLE, 1'b1, EV_NONE, 32'd0, 1'b0);
		add_row(2, 1'b1, 0, PH_IDLE, 1'b0, EV_NONE, 32'd0, 1'b0);
		for (int i = 0; i < 6; i++)
			add_row(0, 1'b1, 0, PH_IDLE, 1'b0, EV_NONE, 32'd0, 1'b0);
		add_row(0, 1'b0, 0, PH_IDLE, 1'b0, EV_NONE, 32'd0, 1'b0);
		for (int i = 0; i < 3; i++)
			add_row(0, 1'b1, 0, PH_IDLE, 1'b0, EV_NONE, 32'd0, 1'b0);
		for (int i = 0; i < 3; i++)
			add_row(0, 1'b0, 0, PH_IDLE, 1'b0, EV_NONE, 32'd0, 1'b0);
		add_row(3, 1'b1, 0, PH_IDLE, 1'b0, EV_NONE, 32'd0, 1'b0);
		add_row(0, 1'b0, 0, PH_IDLE, 1'b0, EV_NONE, 32'd0, 1'b0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].sel != 0) begin
				settle();
				apply_settings(set_db[dir_rows[i].sel], set_to[dir_rows[i].sel],
					set_pol[dir_rows[i].sel]);
			end
			send_tick(dir_rows[i].raw, dir_rows[i].fixed, dir_rows[i].want);
		end

		// hold contact inside the full-scale debounce window
		settle();
		apply_settings(32'h0000_FFFF, $urandom_range(5, 20), 32'h0000_0001);
		repeat (40) send_tick(1'b1, 0, none);

		for (p = 0; p < 6; p++) begin
			settle();
			case (p % 4)
				0: begin db = 0; to = $urandom_range(0, 10); end
				1: begin db = $urandom_range(1, 4); to = $urandom_range(1, 30); end
				2: begin db = $urandom_range(2, 12); to = 32'hFFFF_FFFF; end
				default: begin db = $urandom_range(0, 6); to = $urandom_range(0, 60); end
			endcase
			hi = 16'($urandom);
			apply_settings({hi, db[15:0]}, to, $urandom);
			sent = 0;
			while (sent < 88) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					lvl = ~deb_level;
					run = db + $urandom_range(1, 70);
					repeat (run) send_tick(lvl, 0, none);
				end else if (pick < 9) begin
					lvl = ~prev_raw;
					run = $urandom_range(1, (db > 0) ? db : 1);
					repeat (run) send_tick(lvl, 0, none);
				end else begin
					run = $urandom_range(1, 6);
					repeat (run) send_tick(1'($urandom_range(0, 1)), 0, none);
				end
				sent += run;
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("checked %0d status transactions over %0d register settings",
			n_checked, n_settings);
		$display("saw %0d accepted rises, %0d accepted falls, %0d alarm entries",
			n_rise, n_fall, n_alarm);
		if (errors == 0)
			$display("debounced_contact_timeout_alarm_top_test OK");
		else
			$display("debounced_contact_timeout_alarm_top_test NOT OK");
		$finish;
	end

endmodule
